### hw/rtl/fpa_pkg.sv
// types, operation codes and saturation helpers for the q24.8 fixed-point alu
package fpa_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned QUO_W  = DATA_W + 1;

  typedef enum logic [3:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_GT       = 4'd4,
    MODE_LT       = 4'd5,
    MODE_GE       = 4'd6,
    MODE_LE       = 4'd7,
    MODE_EQ       = 4'd8,
    MODE_NE       = 4'd9,
    MODE_MIN      = 4'd10,
    MODE_MAX      = 4'd11,
    MODE_INC      = 4'd12,
    MODE_DEC      = 4'd13,
    MODE_FROM_INT = 4'd14,
    MODE_TO_INT   = 4'd15
  } mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              cmp;
    logic              ovf;
    logic              dbz;
  } res_t;

  typedef struct packed {
    mode_e              mode;
    logic               neg;
    logic [DATA_W-1:0]  res;
    logic               cmp;
    logic               ovf;
    logic               dbz;
    logic               dov;
    logic [DATA_W-1:0]  mb;
    logic [DATA_W-1:0]  rem;
    logic [QUO_W-1:0]   dvd;
    logic [QUO_W-1:0]   quo;
  } pipe_t;

  // {overflow, value} from a sign and a magnitude
  function automatic logic [DATA_W:0] sat_fn(input logic neg, input logic [63:0] mag);
    logic [DATA_W:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(64'd0 - mag)};
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[DATA_W-1:0]};
    end
    return r;
  endfunction

  // saturate a 33-bit two's-complement sum
  function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] s);
    logic [DATA_W:0] m;
    m = s[DATA_W] ? (33'd0 - s) : s;
    return sat_fn(s[DATA_W], 64'(m));
  endfunction

endpackage

### hw/rtl/fixed_point_alu_q24_8_unit.sv
// pipelined signed fixed-point alu with saturation and restoring divider
//  channel | signals                                         | dir
//  in      | in_valid_i in_stall_o mode_i operand_a_i operand_b_i | in
//  out     | out_valid_o out_stall_i result_value_o compare_true_o
//          | overflowed_o divided_by_zero_o                  | out
// pipe depth is FRACTION_BITS-independent: input, operand and rounding
// registers, the 33 one-bit divider stages and the output register
// one word enters every cycle while in_stall_o is low; a skid register
// behind the output register takes one word while the output is stalled,
// then the whole pipe holds; reset clears all valid bits
module fixed_point_alu_q24_8_unit import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        mode_i,
  input  logic [DATA_W-1:0] operand_a_i,
  input  logic [DATA_W-1:0] operand_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] result_value_o,
  output logic              compare_true_o,
  output logic              overflowed_o,
  output logic              divided_by_zero_o
);

  localparam int unsigned DW = QUO_W + FRACTION_BITS;
  localparam int unsigned NDS = QUO_W + 1;

  logic en;
  logic acc;

  // stage 0: operands
  logic               v0_q;
  mode_e              mode0_q;
  logic signed [31:0] a0_q, b0_q;

  // stage 1: magnitudes, product, simple results
  logic               v1_q;
  mode_e              mode1_q;
  logic               neg1_q, neg1_d;
  logic [31:0]        ma1_q, ma1_d, mb1_q, mb1_d;
  logic [63:0]        prod1_q;
  logic [31:0]        res1_q, res1_d;
  logic               cmp1_q, cmp1_d, ovf1_q, ovf1_d;

  // divider stages
  logic  dv_q [NDS];
  pipe_t dp_q [NDS];
  pipe_t dp_d [NDS];

  // output and skid
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q, fin_d;
  logic take, push;

  assign en = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign acc = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= acc;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode0_q <= mode_e'(mode_i);
      a0_q    <= operand_a_i;
      b0_q    <= operand_b_i;
      mode1_q <= mode0_q;
      neg1_q  <= neg1_d;
      ma1_q   <= ma1_d;
      mb1_q   <= mb1_d;
      prod1_q <= 64'(ma1_d) * 64'(mb1_d);
      res1_q  <= res1_d;
      cmp1_q  <= cmp1_d;
      ovf1_q  <= ovf1_d;
    end
  end

  always_comb begin
    logic [DATA_W:0] s;
    logic signed [31:0] sh;
    s = '0;
    sh = a0_q >>> FRACTION_BITS;
    ma1_d  = a0_q[31] ? (32'd0 - a0_q) : a0_q;
    mb1_d  = b0_q[31] ? (32'd0 - b0_q) : b0_q;
    neg1_d = a0_q[31] ^ b0_q[31];
    res1_d = '0;
    cmp1_d = 1'b0;
    ovf1_d = 1'b0;
    unique case (mode0_q)
      MODE_ADD: begin
        s = {a0_q[31], a0_q} + {b0_q[31], b0_q};
        {ovf1_d, res1_d} = sat_sum(s);
      end
      MODE_SUB: begin
        s = {a0_q[31], a0_q} - {b0_q[31], b0_q};
        {ovf1_d, res1_d} = sat_sum(s);
      end
      MODE_INC: begin
        s = {a0_q[31], a0_q} + 33'd1;
        {ovf1_d, res1_d} = sat_sum(s);
      end
      MODE_DEC: begin
        s = {a0_q[31], a0_q} - 33'd1;
        {ovf1_d, res1_d} = sat_sum(s);
      end
      MODE_GT:  cmp1_d = a0_q > b0_q;
      MODE_LT:  cmp1_d = a0_q < b0_q;
      MODE_GE:  cmp1_d = a0_q >= b0_q;
      MODE_LE:  cmp1_d = a0_q <= b0_q;
      MODE_EQ:  cmp1_d = a0_q == b0_q;
      MODE_NE:  cmp1_d = a0_q != b0_q;
      MODE_MIN: res1_d = (a0_q < b0_q) ? a0_q : b0_q;
      MODE_MAX: res1_d = (a0_q > b0_q) ? a0_q : b0_q;
      MODE_FROM_INT: {ovf1_d, res1_d} = sat_fn(a0_q[31], 64'(ma1_d) << FRACTION_BITS);
      MODE_TO_INT:   res1_d = sh;
      MODE_MUL, MODE_DIV: res1_d = '0;
      default: res1_d = '0;
    endcase
  end

  // rounding of the product and divider setup
  always_comb begin
    logic [63:0] pr;
    logic [DW-1:0] n2;
    logic [31:0] hi;
    pr = prod1_q + (64'd1 << (FRACTION_BITS - 1));
    n2 = DW'(ma1_q) << (FRACTION_BITS + 1);
    hi = 32'(n2[DW-1:QUO_W]);
    dp_d[0].mode = mode1_q;
    dp_d[0].neg  = neg1_q;
    dp_d[0].res  = res1_q;
    dp_d[0].cmp  = cmp1_q;
    dp_d[0].ovf  = ovf1_q;
    if (mode1_q == MODE_MUL) begin
      {dp_d[0].ovf, dp_d[0].res} = sat_fn(neg1_q, pr >> FRACTION_BITS);
    end
    dp_d[0].dbz = (mode1_q == MODE_DIV) && (mb1_q == '0);
    dp_d[0].dov = hi >= mb1_q;
    dp_d[0].mb  = mb1_q;
    dp_d[0].rem = (hi >= mb1_q) ? '0 : hi;
    dp_d[0].dvd = n2[QUO_W-1:0];
    dp_d[0].quo = '0;
  end

  for (genvar j = 1; j < NDS; j++) begin : g_div
    always_comb begin
      logic [DATA_W:0] r2;
      logic            qb;
      r2 = {dp_q[j-1].rem, dp_q[j-1].dvd[QUO_W-1]};
      qb = r2 >= {1'b0, dp_q[j-1].mb};
      dp_d[j]     = dp_q[j-1];
      dp_d[j].rem = qb ? 32'(r2 - {1'b0, dp_q[j-1].mb}) : r2[DATA_W-1:0];
      dp_d[j].dvd = {dp_q[j-1].dvd[QUO_W-2:0], 1'b0};
      dp_d[j].quo = {dp_q[j-1].quo[QUO_W-2:0], qb};
    end
  end

  for (genvar k = 0; k < NDS; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= (k == 0) ? v1_q : dv_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dp_q[k] <= dp_d[k];
      end
    end
  end

  // final rounding of the quotient and result select
  always_comb begin
    logic [QUO_W:0] t;
    pipe_t p;
    p = dp_q[NDS-1];
    t = {1'b0, (p.dov ? {QUO_W{1'b1}} : p.quo)} + (QUO_W+1)'(1);
    fin_d.value = p.res;
    fin_d.cmp   = p.cmp;
    fin_d.ovf   = p.ovf;
    fin_d.dbz   = p.dbz;
    if (p.mode == MODE_DIV) begin
      if (p.dbz) begin
        fin_d.value = '0;
        fin_d.ovf   = 1'b0;
      end else begin
        {fin_d.ovf, fin_d.value} = sat_fn(p.neg, 64'(t[QUO_W:1]));
      end
    end
  end

  assign take = out_v_q && !out_stall_i;
  assign push = dv_q[NDS-1] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (take) skid_v_q <= 1'b0;
      end else if (push) begin
        if (!(!out_v_q || take)) skid_v_q <= 1'b1;
        out_v_q <= 1'b1;
      end else if (take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_q <= skid_q;
    end else if (push) begin
      if (!out_v_q || take) out_q <= fin_d;
      else skid_q <= fin_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign result_value_o    = out_q.value;
  assign compare_true_o    = out_q.cmp;
  assign overflowed_o      = out_q.ovf;
  assign divided_by_zero_o = out_q.dbz;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word without output word");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.dbz |-> out_q.value == '0 && !out_q.ovf)
    else $error("divide by zero word not cleared");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.cmp |-> out_q.value == '0 && !out_q.ovf && !out_q.dbz)
    else $error("compare word carries a value");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q)
    else $error("skid word dropped while stalled");

endmodule
